@@ hw/rtl/gbe_pkg.sv @@
// Package for the gap buffer engine: store geometry, operation codes,
// controller states and the payload and command structs. No dependencies.
`default_nettype none

package gbe_pkg;

  // Store geometry.
  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned POS_W    = 13;

  localparam logic [POS_W-1:0] CAP_POS = POS_W'(CAPACITY);

  // Operation codes carried in the operation field.
  typedef enum logic [1:0] {
    OP_MOVE   = 2'd0,
    OP_READ   = 2'd1,
    OP_INSERT = 2'd2
  } op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_MOVE,
    ST_READ,
    ST_RDATA,
    ST_INSERT,
    ST_RESP
  } state_e;

  // Input word.
  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] offset;
    logic [7:0]       data_byte;
  } in_word_t;

  // Output word.
  typedef struct packed {
    logic [7:0]       read_byte;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] text_length;
    logic             full_flag;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic prep;
    logic step;
    logic read;
    logic rcap;
    logic insert;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] op;
    logic       at_target;
    logic       wr_pend;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/gbe_ctrl.sv @@
// Controller state machine of the gap buffer engine.
// Depends on gbe_pkg for states, operation codes and command/status structs.
`default_nettype none

module gbe_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  input  wire gbe_pkg::status_t status_i,
  output gbe_pkg::cmd_t        cmd_o
);

  gbe_pkg::state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gbe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      gbe_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = gbe_pkg::ST_PREP;
      end
      gbe_pkg::ST_PREP: begin
        case (status_i.op)
          gbe_pkg::OP_MOVE:   state_d = gbe_pkg::ST_MOVE;
          gbe_pkg::OP_READ:   state_d = gbe_pkg::ST_READ;
          gbe_pkg::OP_INSERT: state_d = gbe_pkg::ST_INSERT;
          default:            state_d = gbe_pkg::ST_RESP;
        endcase
      end
      gbe_pkg::ST_MOVE: begin
        // Leave once the gap is in place and the last copy has landed.
        if (status_i.at_target && !status_i.wr_pend) state_d = gbe_pkg::ST_RESP;
      end
      gbe_pkg::ST_READ:   state_d = gbe_pkg::ST_RDATA;
      gbe_pkg::ST_RDATA:  state_d = gbe_pkg::ST_RESP;
      gbe_pkg::ST_INSERT: state_d = gbe_pkg::ST_RESP;
      gbe_pkg::ST_RESP: begin
        if (out_ready_i) state_d = gbe_pkg::ST_IDLE;
      end
      default: state_d = gbe_pkg::ST_IDLE;
    endcase
  end

  // Outputs and datapath commands.
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      gbe_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      gbe_pkg::ST_PREP:   cmd_o.prep   = 1'b1;
      gbe_pkg::ST_MOVE:   cmd_o.step   = !status_i.at_target;
      gbe_pkg::ST_READ:   cmd_o.read   = 1'b1;
      gbe_pkg::ST_RDATA:  cmd_o.rcap   = 1'b1;
      gbe_pkg::ST_INSERT: cmd_o.insert = 1'b1;
      gbe_pkg::ST_RESP:   out_valid_o  = 1'b1;
      default: begin
        cmd_o = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  // A result is offered only after an item was taken and worked on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !in_ready_o && $past(state_q != gbe_pkg::ST_IDLE))
    else $error("result raised without a preceding item");

  // The datapath never gets two operation commands at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cmd_o.accept, cmd_o.prep, cmd_o.step, cmd_o.read, cmd_o.rcap,
                cmd_o.insert}) <= 1)
    else $error("conflicting datapath commands");

  // Input is never taken while a result is still on offer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && !in_ready_o)
    else $error("stalled result dropped");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/gbe_datapath.sv @@
// Datapath of the gap buffer engine: text store, gap pointers, copy
// pipeline and result registers. Depends on gbe_pkg.
`default_nettype none

module gbe_datapath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gbe_pkg::in_word_t in_word_i,
  input  wire gbe_pkg::cmd_t     cmd_i,
  output gbe_pkg::status_t       status_o,
  output gbe_pkg::out_word_t     out_word_o
);

  localparam int unsigned AW = gbe_pkg::ADDR_W;
  localparam int unsigned PW = gbe_pkg::POS_W;

  // Text store.
  logic [7:0] mem [gbe_pkg::CAPACITY];

  // Gap pointers and text length.
  logic [PW-1:0] gs_q, ge_q, len_q;
  // Latched item and clamped target.
  logic [1:0]    op_q;
  logic [PW-1:0] off_q, tgt_q;
  logic [7:0]    byte_q;
  // Copy pipeline and read path.
  logic          wr_pend_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]    rdata_q;
  logic          rd_ok_q;
  // Result fields.
  logic [7:0]    rbyte_q;
  logic          full_q;

  logic          move_left;
  logic [PW-1:0] gap_size;
  logic [PW-1:0] phys;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          gap_empty;

  assign move_left = tgt_q < gs_q;
  assign gap_size  = ge_q - gs_q;
  assign phys      = (tgt_q < gs_q) ? tgt_q : tgt_q + gap_size;
  assign gap_empty = gs_q == ge_q;

  // Read port: copy source during a move, mapped offset for a read.
  always_comb begin
    rd_en   = cmd_i.step || cmd_i.read;
    rd_addr = phys[AW-1:0];
    if (cmd_i.step) begin
      rd_addr = move_left ? AW'(gs_q - PW'(1)) : ge_q[AW-1:0];
    end
  end

  // Write port: pending copy, or an inserted byte.
  always_comb begin
    wr_en   = wr_pend_q;
    wr_addr = wr_addr_q;
    wr_data = rdata_q;
    if (cmd_i.insert && !gap_empty) begin
      wr_en   = 1'b1;
      wr_addr = gs_q[AW-1:0];
      wr_data = byte_q;
    end
  end

  // Store access, read data registered.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Gap pointers, text length and copy pipeline control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q      <= '0;
      ge_q      <= gbe_pkg::CAP_POS;
      len_q     <= '0;
      wr_pend_q <= 1'b0;
    end else begin
      wr_pend_q <= cmd_i.step;
      if (cmd_i.step) begin
        if (move_left) begin
          gs_q <= gs_q - PW'(1);
          ge_q <= ge_q - PW'(1);
        end else begin
          gs_q <= gs_q + PW'(1);
          ge_q <= ge_q + PW'(1);
        end
      end
      if (cmd_i.insert && !gap_empty) begin
        gs_q  <= gs_q + PW'(1);
        len_q <= len_q + PW'(1);
      end
    end
  end

  // Item, target and result registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q    <= in_word_i.operation;
      off_q   <= in_word_i.offset;
      byte_q  <= in_word_i.data_byte;
      rbyte_q <= '0;
      full_q  <= 1'b0;
    end
    if (cmd_i.prep) begin
      tgt_q <= (off_q > len_q) ? len_q : off_q;
    end
    if (cmd_i.step) begin
      wr_addr_q <= move_left ? AW'(ge_q - PW'(1)) : gs_q[AW-1:0];
    end
    if (cmd_i.read) begin
      rd_ok_q <= tgt_q < len_q;
    end
    if (cmd_i.rcap) begin
      rbyte_q <= rd_ok_q ? rdata_q : 8'd0;
    end
    if (cmd_i.insert) begin
      full_q <= gap_empty;
    end
  end

  assign status_o.op        = op_q;
  assign status_o.at_target = tgt_q == gs_q;
  assign status_o.wr_pend   = wr_pend_q;

  assign out_word_o.read_byte   = rbyte_q;
  assign out_word_o.position    = gs_q;
  assign out_word_o.text_length = len_q;
  assign out_word_o.full_flag   = full_q;

`ifndef SYNTHESIS
  // The gap never inverts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gs_q <= ge_q)
    else $error("gap start passed gap end");

  // Text length always equals the capacity minus the gap size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q == gbe_pkg::CAP_POS - (ge_q - gs_q))
    else $error("text length out of step with gap");

  // A copy write never competes with an insert for the write port.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(wr_pend_q && cmd_i.insert))
    else $error("copy write collides with insert");

  // Each copy step is followed by its write.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |=> wr_pend_q)
    else $error("copy step lost its write");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/gap_buffer_engine.sv @@
// Top level of the gap buffer engine: joins the controller and the datapath.
// Depends on gbe_pkg, gbe_ctrl and gbe_datapath.
//
// Usage: one input word (operation, offset, data_byte) is taken on the
// in_valid_i/in_ready_o handshake, and exactly one output word (read_byte,
// position, text_length, full_flag) is returned on out_valid_o/out_ready_i.
// One word is worked on at a time; in_ready_o is high only while idle.
// A gap move that is not already in place runs a copy loop that moves one
// byte per cycle through the registered store read and waits for the last
// write before the result is offered. The next word can be taken in the
// cycle after the result is accepted.
// Offsets beyond the text length are clamped to it.
// Reset makes the whole store gap: empty text, gap at position zero. The
// store contents themselves are not cleared and need no clearing pass.
// While the receiver holds out_ready_i low the result word stays stable
// and no new input word is taken.
`default_nettype none

module gap_buffer_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire gbe_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output gbe_pkg::out_word_t      out_word_o
);

  gbe_pkg::cmd_t    cmd;
  gbe_pkg::status_t status;

  gbe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  gbe_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_word_o (out_word_o)
  );

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for gap_buffer_engine: directed tables, a fill to
// capacity and random edits, checked against table rows or an in-bench gap buffer.
// Depends on gbe_pkg and the gap_buffer_engine RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gbe_pkg::*;

  // Operation code that the package leaves unnamed; it must change nothing.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [POS_W-1:0] OFFSET_MAX = '1;
  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned RANDOM_WORDS = 1250;
  localparam int unsigned FULL_WORDS = 60;

  // One row of a directed table; want is used only when typed is set.
  typedef struct packed {
    logic [1:0]       operation;
    logic [POS_W-1:0] offset;
    logic [7:0]       data_byte;
    logic             typed;
    out_word_t        want;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_word_t  in_word_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_word_o;

  gap_buffer_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the text store and the gap bounds.
  logic [7:0]  text_bytes [CAPACITY];
  int unsigned gap_lo = 0;
  int unsigned gap_hi = CAPACITY;

  out_word_t   awaited_replies [$];
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned mismatches = 0;
  int unsigned replies_seen = 0;
  int unsigned idle_cycles = 0;
  int unsigned op_counts [4] = '{0, 0, 0, 0};
  int unsigned refused_inserts = 0;
  int unsigned longest_text = 0;

  function automatic int unsigned text_len();
    return CAPACITY - (gap_hi - gap_lo);
  endfunction

  // Applies one word to the shadow buffer and returns the reply it causes.
  function automatic out_word_t apply_to_text(in_word_t w);
    out_word_t   r;
    int unsigned len;
    int unsigned target;
    int unsigned phys;
    r = '0;
    len = text_len();
    target = (int'(w.offset) > len) ? len : int'(w.offset);
    case (w.operation)
      OP_MOVE: begin
        while (target < gap_lo) begin
          gap_lo--;
          gap_hi--;
          text_bytes[gap_hi] = text_bytes[gap_lo];
        end
        while (target > gap_lo) begin
          text_bytes[gap_lo] = text_bytes[gap_hi];
          gap_lo++;
          gap_hi++;
        end
      end
      OP_READ: begin
        // A read at the end of the text addresses no byte.
        if (target < len) begin
          phys = (target < gap_lo) ? target : target + (gap_hi - gap_lo);
          r.read_byte = text_bytes[phys];
        end
      end
      OP_INSERT: begin
        if (gap_lo >= gap_hi) begin
          r.full_flag = 1'b1;
        end else begin
          text_bytes[gap_lo] = w.data_byte;
          gap_lo++;
        end
      end
      default: ;
    endcase
    r.position = POS_W'(gap_lo);
    r.text_length = POS_W'(text_len());
    return r;
  endfunction

  // Random edit; gap moves are mostly short so that the copy loop stays cheap.
  function automatic in_word_t random_edit();
    in_word_t    w;
    int unsigned len;
    int unsigned pick;
    int unsigned lo;
    len = text_len();
    w.data_byte = 8'($urandom);
    pick = $urandom_range(99);
    if (pick < 5) begin
      w.operation = OP_UNUSED;
    end else if (pick < 40) begin
      w.operation = OP_INSERT;
    end else if (pick < 70) begin
      w.operation = OP_READ;
    end else begin
      w.operation = OP_MOVE;
    end
    pick = $urandom_range(99);
    if (w.operation == OP_MOVE && pick < 80) begin
      lo = (gap_lo > 16) ? gap_lo - 16 : 0;
      w.offset = POS_W'($urandom_range(gap_lo + 16, lo));
    end else if (pick < 88) begin
      w.offset = POS_W'($urandom_range(len, 0));
    end else if (pick < 94) begin
      w.offset = POS_W'(len);
    end else begin
      w.offset = POS_W'($urandom_range(int'(OFFSET_MAX), len));
    end
    return w;
  endfunction

  // Offers one word, waits for it to be taken, and records its reply.
  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    int unsigned gap;
    out_word_t   predicted;
    gap = (idle_on && $urandom_range(99) < 30) ? $urandom_range(4, 1) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = apply_to_text(w);
    awaited_replies.push_back(typed ? want : predicted);
    op_counts[w.operation]++;
    if (predicted.full_flag) refused_inserts++;
    if (text_len() > longest_text) longest_text = text_len();
  endtask

  // Checks one returned word against the oldest expectation.
  task automatic take_reply(out_word_t got);
    out_word_t want;
    replies_seen++;
    if (awaited_replies.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("Unexpected reply: byte %02h pos %0d len %0d full %0b",
                 got.read_byte, got.position, got.text_length, got.full_flag);
      end
    end else begin
      want = awaited_replies.pop_front();
      if (got.read_byte !== want.read_byte || got.position !== want.position ||
          got.text_length !== want.text_length || got.full_flag !== want.full_flag) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Reply %0d mismatch: expected byte %02h pos %0d len %0d full %0b,",
                   replies_seen, want.read_byte, want.position, want.text_length,
                   want.full_flag);
          $display("  got byte %02h pos %0d len %0d full %0b",
                   got.read_byte, got.position, got.text_length, got.full_flag);
        end
      end
    end
  endtask

  // Receiver: checks replies and stalls at random, once for a long stretch.
  initial begin
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) take_reply(out_word_o);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= !(idle_on && $urandom_range(99) < 30);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Stimulus.
  initial begin
    stim_row_t empty_plan [23];
    stim_row_t full_plan [13];
    in_word_t  w;

    // From reset the text is empty; the first rows can be read off directly.
    empty_plan = '{
      '{OP_READ,   13'd0,      8'h00, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{OP_READ,   OFFSET_MAX, 8'h00, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{OP_MOVE,   OFFSET_MAX, 8'h00, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{OP_UNUSED, OFFSET_MAX, 8'hff, 1'b1, '{8'h00, 13'd0, 13'd0, 1'b0}},
      '{OP_INSERT, 13'd0,      8'hff, 1'b1, '{8'h00, 13'd1, 13'd1, 1'b0}},
      '{OP_INSERT, OFFSET_MAX, 8'h00, 1'b1, '{8'h00, 13'd2, 13'd2, 1'b0}},
      '{OP_INSERT, 13'd0,      8'ha5, 1'b1, '{8'h00, 13'd3, 13'd3, 1'b0}},
      '{OP_MOVE,   13'd0,      8'h00, 1'b1, '{8'h00, 13'd0, 13'd3, 1'b0}},
      '{OP_READ,   13'd0,      8'h00, 1'b1, '{8'hff, 13'd0, 13'd3, 1'b0}},
      '{OP_READ,   13'd1,      8'h00, 1'b1, '{8'h00, 13'd0, 13'd3, 1'b0}},
      '{OP_READ,   13'd2,      8'h00, 1'b1, '{8'ha5, 13'd0, 13'd3, 1'b0}},
      '{OP_READ,   13'd3,      8'h00, 1'b1, '{8'h00, 13'd0, 13'd3, 1'b0}},
      '{OP_READ,   OFFSET_MAX, 8'h00, 1'b1, '{8'h00, 13'd0, 13'd3, 1'b0}},
      '{OP_INSERT, 13'd0,      8'h5a, 1'b1, '{8'h00, 13'd1, 13'd4, 1'b0}},
      '{OP_MOVE,   13'd3,      8'h00, 1'b0, '0},
      '{OP_READ,   13'd0,      8'h00, 1'b0, '0},
      '{OP_READ,   13'd3,      8'h00, 1'b0, '0},
      '{OP_MOVE,   13'd4096,   8'h00, 1'b0, '0},
      '{OP_INSERT, 13'd0,      8'h81, 1'b0, '0},
      '{OP_MOVE,   13'd1,      8'h00, 1'b0, '0},
      '{OP_UNUSED, 13'd2,      8'h3c, 1'b0, '0},
      '{OP_READ,   13'd5,      8'h00, 1'b0, '0},
      '{OP_READ,   13'd4,      8'h00, 1'b0, '0}
    };

    // With the store full: refused inserts, reads at both ends, long moves.
    full_plan = '{
      '{OP_INSERT, 13'd0,      8'hff, 1'b0, '0},
      '{OP_INSERT, OFFSET_MAX, 8'h00, 1'b0, '0},
      '{OP_READ,   13'd0,      8'h00, 1'b0, '0},
      '{OP_READ,   13'd4095,   8'h00, 1'b0, '0},
      '{OP_READ,   13'd4096,   8'h00, 1'b0, '0},
      '{OP_READ,   OFFSET_MAX, 8'h00, 1'b0, '0},
      '{OP_MOVE,   13'd0,      8'h00, 1'b0, '0},
      '{OP_INSERT, 13'd0,      8'h7e, 1'b0, '0},
      '{OP_MOVE,   OFFSET_MAX, 8'h00, 1'b0, '0},
      '{OP_READ,   13'd4095,   8'h00, 1'b0, '0},
      '{OP_UNUSED, OFFSET_MAX, 8'hff, 1'b0, '0},
      '{OP_MOVE,   13'd2048,   8'h00, 1'b0, '0},
      '{OP_INSERT, 13'd2048,   8'h01, 1'b0, '0}
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (empty_plan[i]) begin
      w = '{empty_plan[i].operation, empty_plan[i].offset, empty_plan[i].data_byte};
      send_word(w, empty_plan[i].typed, empty_plan[i].want);
    end

    // Random edits; a quiet stretch in the middle and one long receiver stall.
    for (int unsigned n = 0; n < RANDOM_WORDS; n++) begin
      idle_on = !(n >= 400 && n < 700);
      if (n == 800) hold_req = 1'b1;
      send_word(random_edit(), 1'b0, '0);
    end
    idle_on = 1'b1;

    // Fill the store, then work on it while full.
    while (text_len() < CAPACITY) begin
      w = '{OP_INSERT, POS_W'($urandom), 8'($urandom)};
      send_word(w, 1'b0, '0);
    end
    foreach (full_plan[i]) begin
      w = '{full_plan[i].operation, full_plan[i].offset, full_plan[i].data_byte};
      send_word(w, full_plan[i].typed, full_plan[i].want);
    end
    for (int unsigned n = 0; n < FULL_WORDS; n++) begin
      send_word(random_edit(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // Drain, then allow a few more cycles for anything unrequested.
    while (awaited_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d moves, %0d reads, %0d inserts and %0d unused codes; %0d replies.",
             op_counts[OP_MOVE], op_counts[OP_READ], op_counts[OP_INSERT],
             op_counts[OP_UNUSED], replies_seen);
    $display("Text grew to %0d bytes; %0d inserts were refused on a full store.",
             longest_text, refused_inserts);
    if (mismatches == 0 && awaited_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d replies missing", mismatches, awaited_replies.size());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
